FILE: rtl/cpu8ex_pkg.sv
`default_nettype none

package cpu8ex_pkg;

   // Command codes carried on the request channel.
   typedef enum logic [4:0] {
      CMD_ADC     = 5'd0,
      CMD_SBC     = 5'd1,
      CMD_AND     = 5'd2,
      CMD_ASL_ACC = 5'd3,
      CMD_ASL_MEM = 5'd4,
      CMD_BIT     = 5'd5,
      CMD_BCC     = 5'd6,
      CMD_BCS     = 5'd7,
      CMD_BEQ     = 5'd8,
      CMD_BNE     = 5'd9,
      CMD_BMI     = 5'd10,
      CMD_BPL     = 5'd11,
      CMD_BVC     = 5'd12,
      CMD_BVS     = 5'd13,
      CMD_CLC     = 5'd14,
      CMD_CLD     = 5'd15,
      CMD_CLI     = 5'd16,
      CMD_CLV     = 5'd17,
      CMD_TAX     = 5'd18,
      CMD_TAY     = 5'd19,
      CMD_TSX     = 5'd20,
      CMD_TXA     = 5'd21,
      CMD_TXS     = 5'd22,
      CMD_TYA     = 5'd23,
      CMD_NOP     = 5'd24
   } cmd_type;

   // Bit positions in the status byte.
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_N = 7;

   // Branch penalties.
   localparam logic [1:0] EXTRA_NONE  = 2'd0;
   localparam logic [1:0] EXTRA_TAKEN = 2'd1;
   localparam logic [1:0] EXTRA_PAGE  = 2'd2;

   // Architectural register file of the execute stage.
   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] flags;
   } arch_state_type;

   // Payload of one request transaction.
   typedef struct packed {
      logic [4:0]        command;
      logic [7:0]        operand;
      logic [15:0]       prog_counter;
      logic signed [7:0] displacement;
   } req_data_type;

   // Payload of one response transaction.
   typedef struct packed {
      logic [7:0]  acc_out;
      logic [7:0]  x_out;
      logic [7:0]  y_out;
      logic [7:0]  sp_out;
      logic [7:0]  status_out;
      logic [7:0]  write_data;
      logic        write_enable;
      logic [15:0] next_pc;
      logic [1:0]  extra_cycles;
      logic        may_extend;
   } rsp_data_type;

endpackage

`default_nettype wire

FILE: rtl/cpu8ex_channels.sv
`default_nettype none

// Request channel: one decoded instruction per transaction.
interface cpu8ex_req_if;
   logic              valid;
   logic              ready;
   logic [4:0]        command;
   logic [7:0]        operand;
   logic [15:0]       prog_counter;
   logic signed [7:0] displacement;

   modport source (output valid, command, operand, prog_counter, displacement,
                   input ready);
   modport sink (input valid, command, operand, prog_counter, displacement,
                 output ready);
endinterface

// Response channel: register file and branch outcome per transaction.
interface cpu8ex_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  acc_out;
   logic [7:0]  x_out;
   logic [7:0]  y_out;
   logic [7:0]  sp_out;
   logic [7:0]  status_out;
   logic [7:0]  write_data;
   logic        write_enable;
   logic [15:0] next_pc;
   logic [1:0]  extra_cycles;
   logic        may_extend;

   modport source (output valid, acc_out, x_out, y_out, sp_out, status_out,
                   write_data, write_enable, next_pc, extra_cycles, may_extend,
                   input ready);
   modport sink (input valid, acc_out, x_out, y_out, sp_out, status_out,
                 write_data, write_enable, next_pc, extra_cycles, may_extend,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/cpu8ex_alu.sv
`default_nettype none

module cpu8ex_alu import cpu8ex_pkg::*; (
   input  arch_state_type state,
   input  req_data_type   req,
   output arch_state_type next_state,
   output rsp_data_type   result
);

   cmd_type     cmd;
   logic [7:0]  addend;
   logic [8:0]  sum;
   logic [7:0]  shifted;
   logic [15:0] target;
   logic        taken;

   assign cmd = cmd_type'(req.command);

   // Shared adder: SBC adds the ones' complement of the operand.
   assign addend = (cmd == CMD_SBC) ? ~req.operand : req.operand;
   assign sum    = {1'b0, state.acc} + {1'b0, addend} + {8'd0, state.flags[FLAG_C]};

   // Shift source is the accumulator or the memory operand.
   assign shifted = (cmd == CMD_ASL_MEM) ? {req.operand[6:0], 1'b0}
                                         : {state.acc[6:0], 1'b0};

   // Branch target wraps modulo 64K.
   assign target = req.prog_counter + {{8{req.displacement[7]}}, req.displacement};

   // Branch condition test.
   always_comb begin
      case (cmd)
         CMD_BCC: taken = !state.flags[FLAG_C];
         CMD_BCS: taken =  state.flags[FLAG_C];
         CMD_BEQ: taken =  state.flags[FLAG_Z];
         CMD_BNE: taken = !state.flags[FLAG_Z];
         CMD_BMI: taken =  state.flags[FLAG_N];
         CMD_BPL: taken = !state.flags[FLAG_N];
         CMD_BVC: taken = !state.flags[FLAG_V];
         CMD_BVS: taken =  state.flags[FLAG_V];
         default: taken = 1'b0;
      endcase
   end

   // Register and flag update for each command.
   always_comb begin
      next_state          = state;
      result.write_data   = 8'd0;
      result.write_enable = 1'b0;
      result.next_pc      = req.prog_counter;
      result.extra_cycles = EXTRA_NONE;
      result.may_extend   = 1'b0;

      case (cmd)
         CMD_ADC, CMD_SBC: begin
            next_state.acc           = sum[7:0];
            next_state.flags[FLAG_C] = sum[8];
            next_state.flags[FLAG_V] = ~(state.acc[7] ^ addend[7]) & (state.acc[7] ^ sum[7]);
            next_state.flags[FLAG_Z] = (sum[7:0] == 8'd0);
            next_state.flags[FLAG_N] = sum[7];
            result.may_extend        = 1'b1;
         end
         CMD_AND: begin
            next_state.acc           = state.acc & req.operand;
            next_state.flags[FLAG_Z] = ((state.acc & req.operand) == 8'd0);
            next_state.flags[FLAG_N] = state.acc[7] & req.operand[7];
            result.may_extend        = 1'b1;
         end
         CMD_ASL_ACC: begin
            next_state.acc           = shifted;
            next_state.flags[FLAG_C] = state.acc[7];
            next_state.flags[FLAG_Z] = (shifted == 8'd0);
            next_state.flags[FLAG_N] = shifted[7];
         end
         CMD_ASL_MEM: begin
            next_state.flags[FLAG_C] = req.operand[7];
            next_state.flags[FLAG_Z] = (shifted == 8'd0);
            next_state.flags[FLAG_N] = shifted[7];
            result.write_data        = shifted;
            result.write_enable      = 1'b1;
         end
         CMD_BIT: begin
            next_state.flags[FLAG_Z] = ((state.acc & req.operand) == 8'd0);
            next_state.flags[FLAG_N] = req.operand[7];
            next_state.flags[FLAG_V] = req.operand[6];
         end
         CMD_BCC, CMD_BCS, CMD_BEQ, CMD_BNE, CMD_BMI, CMD_BPL, CMD_BVC, CMD_BVS: begin
            if (taken) begin
               result.next_pc      = target;
               result.extra_cycles = (target[15:8] != req.prog_counter[15:8]) ? EXTRA_PAGE
                                                                              : EXTRA_TAKEN;
            end
         end
         CMD_CLC: next_state.flags[FLAG_C] = 1'b0;
         CMD_CLD: next_state.flags[FLAG_D] = 1'b0;
         CMD_CLI: next_state.flags[FLAG_I] = 1'b0;
         CMD_CLV: next_state.flags[FLAG_V] = 1'b0;
         CMD_TAX: begin
            next_state.x             = state.acc;
            next_state.flags[FLAG_Z] = (state.acc == 8'd0);
            next_state.flags[FLAG_N] = state.acc[7];
         end
         CMD_TAY: begin
            next_state.y             = state.acc;
            next_state.flags[FLAG_Z] = (state.acc == 8'd0);
            next_state.flags[FLAG_N] = state.acc[7];
         end
         CMD_TSX: begin
            next_state.x             = state.sp;
            next_state.flags[FLAG_Z] = (state.sp == 8'd0);
            next_state.flags[FLAG_N] = state.sp[7];
         end
         CMD_TXA: begin
            next_state.acc           = state.x;
            next_state.flags[FLAG_Z] = (state.x == 8'd0);
            next_state.flags[FLAG_N] = state.x[7];
         end
         CMD_TXS: next_state.sp = state.x;
         CMD_TYA: begin
            next_state.acc           = state.y;
            next_state.flags[FLAG_Z] = (state.y == 8'd0);
            next_state.flags[FLAG_N] = state.y[7];
         end
         default: ;
      endcase

      result.acc_out    = next_state.acc;
      result.x_out      = next_state.x;
      result.y_out      = next_state.y;
      result.sp_out     = next_state.sp;
      result.status_out = next_state.flags;
   end

endmodule

`default_nettype wire

FILE: rtl/cpu8_execute_unit.sv
// Execute stage of an 8-bit accumulator processor with A, X, Y, SP and P.
// req_chan carries one decoded instruction per transaction: command code,
// operand byte, program counter past the instruction and branch offset.
// rsp_chan returns, per instruction, the register file after execution,
// the write-back byte for a memory shift, the next program counter and the
// branch cycle penalty.
// A transaction is captured in an input register; once the output register is
// free or drained, the combinational ALU result moves into the output register
// and the register file is updated. One instruction per cycle is sustained
// while rsp_chan does not stall, set by the one-stage ALU and flag logic
// between the two registers.
// When rsp_chan stalls, the output register holds its transaction and the
// input register can still take one more; req_chan.ready drops only when
// both are full and the response is not being taken.
// Synchronous reset clears both stages and sets A, X, Y, SP and all flags
// to zero.
`default_nettype none

module cpu8_execute_unit import cpu8ex_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   cpu8ex_req_if.sink   req_chan,
   cpu8ex_rsp_if.source rsp_chan
);

   logic           in_valid_ff;
   req_data_type   in_data_ff;
   logic           rsp_valid_ff;
   rsp_data_type   rsp_data_ff;
   arch_state_type arch_ff;
   arch_state_type arch_in;
   rsp_data_type   rsp_data_in;
   logic           advance;

   // The input stage moves forward when the output register is free or drained.
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff.command      <= req_chan.command;
         in_data_ff.operand      <= req_chan.operand;
         in_data_ff.prog_counter <= req_chan.prog_counter;
         in_data_ff.displacement <= req_chan.displacement;
      end
   end

   // Execute logic.
   cpu8ex_alu u_alu (
      .state      (arch_ff),
      .req        (in_data_ff),
      .next_state (arch_in),
      .result     (rsp_data_in)
   );

   // Register file and output register update together.
   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            arch_ff      <= arch_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Response channel outputs.
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.acc_out      = rsp_data_ff.acc_out;
   assign rsp_chan.x_out        = rsp_data_ff.x_out;
   assign rsp_chan.y_out        = rsp_data_ff.y_out;
   assign rsp_chan.sp_out       = rsp_data_ff.sp_out;
   assign rsp_chan.status_out   = rsp_data_ff.status_out;
   assign rsp_chan.write_data   = rsp_data_ff.write_data;
   assign rsp_chan.write_enable = rsp_data_ff.write_enable;
   assign rsp_chan.next_pc      = rsp_data_ff.next_pc;
   assign rsp_chan.extra_cycles = rsp_data_ff.extra_cycles;
   assign rsp_chan.may_extend   = rsp_data_ff.may_extend;

   // An executed instruction always shows up on the response channel next cycle.
   a_advance_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("executed instruction did not reach the response register");

   // The register file changes only when an instruction executes.
   a_state_stable: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(arch_ff))
      else $error("register file changed without an executed instruction");

   // A memory shift leaves A, X and SP untouched.
   a_asl_mem_regs: assert property (@(posedge clock) disable iff (reset)
      (advance && cmd_type'(in_data_ff.command) == CMD_ASL_MEM)
      |=> (arch_ff.acc == $past(arch_ff.acc)) && (arch_ff.x == $past(arch_ff.x))
          && (arch_ff.sp == $past(arch_ff.sp)))
      else $error("memory shift modified a register");

   // The branch penalty stays within its defined codes, and a memory write carries no branch penalty.
   a_extra_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.extra_cycles != 2'd3)
                         && !(rsp_chan.write_enable && rsp_chan.extra_cycles != EXTRA_NONE))
      else $error("inconsistent branch penalty on response");

endmodule

`default_nettype wire
